// ===== rtl/rk4_stage_accumulator_core_assert.svh =====
// ----------------------------------------------------------------------------
// RK4 stage accumulator - assertion macros
// Shared wrappers for the concurrent checks of the accumulator core.
// ----------------------------------------------------------------------------
`ifndef RK4_STAGE_ACCUMULATOR_CORE_ASSERT_SVH
`define RK4_STAGE_ACCUMULATOR_CORE_ASSERT_SVH

// Check that is switched off while reset is asserted.
`define RK4SA_CHECK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define RK4SA_CHECK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rk4sa_pkg.sv =====
// ----------------------------------------------------------------------------
// RK4 stage accumulator - package
// Shared widths, codes and the command type passed from front to back.
// ----------------------------------------------------------------------------
package rk4sa_pkg;

  localparam int DATA_W  = 32;
  localparam int ELEM_W  = 4;
  localparam int STAGE_W = 3;
  localparam int DT_W    = 16;
  localparam int SUM_W   = 35;   // k1 + 2k2 + 2k3 + k4
  localparam int PROD_W  = 52;   // SUM_W x (DT_W + 1)
  localparam int QV_W    = 34;   // rounded magnitude before the divide by 3
  localparam int PP_W    = 51;   // QV_W x 17
  localparam int TERM_W  = 34;   // signed update term

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_DERIV = 1'b1;

  localparam logic [STAGE_W-1:0] STAGE_ONE   = 3'd1;
  localparam logic [STAGE_W-1:0] STAGE_TWO   = 3'd2;
  localparam logic [STAGE_W-1:0] STAGE_THREE = 3'd3;
  localparam logic [STAGE_W-1:0] STAGE_FOUR  = 3'd4;

  localparam logic [DT_W-1:0] TIMESTEP_RST = 16'd655;

  // ceil(2^35 / 3): exact floor(u/3) as (u * RECIP_THREE) >> 35 for u < 2^34
  localparam logic [QV_W-1:0] RECIP_THREE = 34'h2AAAAAAAB;

  // 3 * 2^32: at or above this the stage four quotient saturates anyway
  localparam logic [QV_W:0] FINAL_CLAMP = 35'h300000000;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SLOPE1,
    OP_SLOPE2,
    OP_SLOPE3,
    OP_FINAL
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [ELEM_W-1:0]  element;
    logic [DATA_W-1:0]  operand;
  } cmd_t;

endpackage

// ===== rtl/rk4sa_fifo.sv =====
// ----------------------------------------------------------------------------
// RK4 stage accumulator - command queue
// Small flop queue that decouples the accepting front from the datapath.
// ----------------------------------------------------------------------------
module rk4sa_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rk4sa_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output rk4sa_pkg::cmd_t pop_cmd,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rk4sa_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/rk4sa_front.sv =====
// ----------------------------------------------------------------------------
// RK4 stage accumulator - front end
// Accepts input transactions, drops illegal ones, encodes the operation.
// ----------------------------------------------------------------------------
module rk4sa_front #(
  parameter int VECTOR_LENGTH = 16
) (
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic [rk4sa_pkg::ELEM_W-1:0]       in_element,
  input  logic [rk4sa_pkg::STAGE_W-1:0]      in_stage,
  input  logic signed [rk4sa_pkg::DATA_W-1:0] in_operand,
  input  logic                               q_full,
  output logic                               q_push,
  output rk4sa_pkg::cmd_t                    q_cmd
);

  logic            elem_ok;
  logic            stage_ok;
  rk4sa_pkg::op_t  op;

  assign elem_ok = (32'(in_element) < VECTOR_LENGTH);

  always_comb begin
    stage_ok = 1'b1;
    op       = rk4sa_pkg::OP_LOAD;
    if (in_kind == rk4sa_pkg::KIND_DERIV) begin
      case (in_stage)
        rk4sa_pkg::STAGE_ONE:   op = rk4sa_pkg::OP_SLOPE1;
        rk4sa_pkg::STAGE_TWO:   op = rk4sa_pkg::OP_SLOPE2;
        rk4sa_pkg::STAGE_THREE: op = rk4sa_pkg::OP_SLOPE3;
        rk4sa_pkg::STAGE_FOUR:  op = rk4sa_pkg::OP_FINAL;
        default:                stage_ok = 1'b0;
      endcase
    end
  end

  // out-of-range element or stage: taken and silently dropped
  assign in_stall      = q_full || !rst_n;
  assign q_push        = in_valid && !in_stall && elem_ok && stage_ok;
  assign q_cmd.op      = op;
  assign q_cmd.element = in_element;
  assign q_cmd.operand = in_operand;

endmodule

// ===== rtl/rk4sa_back.sv =====
// ----------------------------------------------------------------------------
// RK4 stage accumulator - back end
// Six-stage datapath: slope store, multiply by dt, round, divide by three,
// state update with saturation, output register.
// ----------------------------------------------------------------------------
module rk4sa_back #(
  parameter int VECTOR_LENGTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [rk4sa_pkg::DT_W-1:0]          timestep,
  input  logic                                q_empty,
  input  rk4sa_pkg::cmd_t                     q_cmd,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rk4sa_pkg::ELEM_W-1:0]        out_element_out,
  output logic signed [rk4sa_pkg::DATA_W-1:0] out_result_value,
  output logic                                out_is_new_state
);

  localparam int DEPTH = (VECTOR_LENGTH < 16) ? VECTOR_LENGTH : 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = rk4sa_pkg::DATA_W;
  localparam int EW    = rk4sa_pkg::ELEM_W;
  localparam int SW    = rk4sa_pkg::SUM_W;
  localparam int PW    = rk4sa_pkg::PROD_W;
  localparam int QW    = rk4sa_pkg::QV_W;
  localparam int PPW   = rk4sa_pkg::PP_W;
  localparam int TW    = rk4sa_pkg::TERM_W;

  // per-element storage; a clear valid bit reads as zero
  logic [DW-1:0] slope1_r [DEPTH];
  logic [DW-1:0] slope2_r [DEPTH];
  logic [DW-1:0] slope3_r [DEPTH];
  logic [DW-1:0] state_r  [DEPTH];
  logic [DEPTH-1:0] slope1_vld_r, slope2_vld_r, slope3_vld_r, state_vld_r;

  logic adv;
  logic out_valid_r;

  // stage 1: slope sum
  logic              s1_vld_r;
  rk4sa_pkg::op_t    s1_op_r;
  logic [EW-1:0]     s1_elem_r;
  logic signed [SW-1:0] s1_sum_r, s1_sum_nxt;
  // stage 2: product
  logic              s2_vld_r;
  rk4sa_pkg::op_t    s2_op_r;
  logic [EW-1:0]     s2_elem_r;
  logic [DW-1:0]     s2_val_r;
  logic signed [PW-1:0] s2_prod_r, s2_prod_nxt;
  // stage 3: rounded magnitude
  logic              s3_vld_r;
  rk4sa_pkg::op_t    s3_op_r;
  logic [EW-1:0]     s3_elem_r;
  logic [DW-1:0]     s3_val_r;
  logic              s3_neg_r, s3_big_r, s3_big_nxt;
  logic [QW-1:0]     s3_qv_r, s3_qv_nxt;
  // stage 4: partial products of the divide by three
  logic              s4_vld_r;
  rk4sa_pkg::op_t    s4_op_r;
  logic [EW-1:0]     s4_elem_r;
  logic [DW-1:0]     s4_val_r;
  logic              s4_neg_r, s4_big_r;
  logic [QW-1:0]     s4_qv_r;
  logic [PPW-1:0]    s4_pp_lo_r, s4_pp_hi_r;
  // stage 5: signed update term
  logic              s5_vld_r;
  rk4sa_pkg::op_t    s5_op_r;
  logic [EW-1:0]     s5_elem_r;
  logic [DW-1:0]     s5_val_r;
  logic signed [TW-1:0] s5_term_r, s5_term_nxt;

  logic [AW-1:0]        q_idx, s5_idx;
  logic signed [DW-1:0] k1, k2, k3, kx, xs;
  logic [PW-1:0]        mag, rnd, rconst;
  logic [PPW+16:0]      full_q;
  logic [DW:0]          mag_q;
  logic signed [SW-1:0] upd;
  logic signed [DW-1:0] res;
  logic                 wr_state;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;
  assign q_idx = q_cmd.element[AW-1:0];
  assign s5_idx = s5_elem_r[AW-1:0];

  // ---- issue: slope read and sum --------------------------------------------
  always_comb begin
    k1 = slope1_vld_r[q_idx] ? slope1_r[q_idx] : '0;
    k2 = slope2_vld_r[q_idx] ? slope2_r[q_idx] : '0;
    k3 = slope3_vld_r[q_idx] ? slope3_r[q_idx] : '0;
    kx = q_cmd.operand;
    if (q_cmd.op == rk4sa_pkg::OP_FINAL) begin
      s1_sum_nxt = {{3{k1[DW-1]}}, k1} + {{2{k2[DW-1]}}, k2, 1'b0}
                 + {{2{k3[DW-1]}}, k3, 1'b0} + {{3{kx[DW-1]}}, kx};
    end else begin
      s1_sum_nxt = {{3{kx[DW-1]}}, kx};
    end
  end

  // ---- multiply by dt ---------------------------------------------------------
  assign s2_prod_nxt = s1_sum_r * $signed({1'b0, timestep});

  // ---- magnitude, round, shift ------------------------------------------------
  // stage four rounds with half of 6*2^16, then takes >>17 and /3 below
  always_comb begin
    mag = s2_prod_r[PW-1] ? PW'(-s2_prod_r) : PW'(s2_prod_r);
    case (s2_op_r)
      rk4sa_pkg::OP_SLOPE1,
      rk4sa_pkg::OP_SLOPE2: rconst = PW'(1) << 16;
      rk4sa_pkg::OP_SLOPE3: rconst = PW'(1) << 15;
      rk4sa_pkg::OP_FINAL:  rconst = PW'(3) << 16;
      default:              rconst = '0;
    endcase
    rnd = mag + rconst;
    s3_big_nxt = (s2_op_r == rk4sa_pkg::OP_FINAL) && (rnd[PW-1:17] >= rk4sa_pkg::FINAL_CLAMP);
    if (s3_big_nxt) begin
      s3_qv_nxt = '0;
    end else if (s2_op_r == rk4sa_pkg::OP_SLOPE3) begin
      s3_qv_nxt = rnd[QW+15:16];
    end else begin
      s3_qv_nxt = rnd[QW+16:17];
    end
  end

  // ---- quotient and sign ------------------------------------------------------
  always_comb begin
    full_q = {s4_pp_hi_r, 17'd0} + {17'd0, s4_pp_lo_r};
    if (s4_op_r == rk4sa_pkg::OP_FINAL) begin
      mag_q = s4_big_r ? {1'b1, {DW{1'b0}}} : {1'b0, full_q[DW+34:35]};
    end else begin
      mag_q = s4_qv_r[DW:0];
    end
    s5_term_nxt = s4_neg_r ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  end

  // ---- state update with saturation ----------------------------------------
  always_comb begin
    xs  = state_vld_r[s5_idx] ? state_r[s5_idx] : '0;
    upd = {{3{xs[DW-1]}}, xs} + {s5_term_r[TW-1], s5_term_r};
    if (s5_op_r == rk4sa_pkg::OP_LOAD) begin
      res = s5_val_r;
    end else if (!upd[SW-1] && (|upd[SW-2:DW-1])) begin
      res = {1'b0, {(DW-1){1'b1}}};
    end else if (upd[SW-1] && !(&upd[SW-2:DW-1])) begin
      res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res = upd[DW-1:0];
    end
    wr_state = adv && s5_vld_r &&
               ((s5_op_r == rk4sa_pkg::OP_LOAD) || (s5_op_r == rk4sa_pkg::OP_FINAL));
  end

  // ---- control registers ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      s3_vld_r     <= 1'b0;
      s4_vld_r     <= 1'b0;
      s5_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      slope1_vld_r <= '0;
      slope2_vld_r <= '0;
      slope3_vld_r <= '0;
      state_vld_r  <= '0;
    end else begin
      if (adv) begin
        s1_vld_r    <= q_pop;
        s2_vld_r    <= s1_vld_r;
        s3_vld_r    <= s2_vld_r;
        s4_vld_r    <= s3_vld_r;
        s5_vld_r    <= s4_vld_r;
        out_valid_r <= s5_vld_r;
      end
      if (q_pop && q_cmd.op == rk4sa_pkg::OP_SLOPE1) begin
        slope1_vld_r[q_idx] <= 1'b1;
      end
      if (q_pop && q_cmd.op == rk4sa_pkg::OP_SLOPE2) begin
        slope2_vld_r[q_idx] <= 1'b1;
      end
      if (q_pop && q_cmd.op == rk4sa_pkg::OP_SLOPE3) begin
        slope3_vld_r[q_idx] <= 1'b1;
      end
      if (wr_state) begin
        state_vld_r[s5_idx] <= 1'b1;
      end
    end
  end

  // ---- payload registers ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == rk4sa_pkg::OP_SLOPE1) begin
      slope1_r[q_idx] <= q_cmd.operand;
    end
    if (q_pop && q_cmd.op == rk4sa_pkg::OP_SLOPE2) begin
      slope2_r[q_idx] <= q_cmd.operand;
    end
    if (q_pop && q_cmd.op == rk4sa_pkg::OP_SLOPE3) begin
      slope3_r[q_idx] <= q_cmd.operand;
    end
    if (wr_state) begin
      state_r[s5_idx] <= res;
    end
    if (adv) begin
      s1_op_r    <= q_cmd.op;
      s1_elem_r  <= q_cmd.element;
      s1_sum_r   <= s1_sum_nxt;

      s2_op_r    <= s1_op_r;
      s2_elem_r  <= s1_elem_r;
      s2_val_r   <= s1_sum_r[DW-1:0];
      s2_prod_r  <= s2_prod_nxt;

      s3_op_r    <= s2_op_r;
      s3_elem_r  <= s2_elem_r;
      s3_val_r   <= s2_val_r;
      s3_neg_r   <= s2_prod_r[PW-1];
      s3_big_r   <= s3_big_nxt;
      s3_qv_r    <= s3_qv_nxt;

      s4_op_r    <= s3_op_r;
      s4_elem_r  <= s3_elem_r;
      s4_val_r   <= s3_val_r;
      s4_neg_r   <= s3_neg_r;
      s4_big_r   <= s3_big_r;
      s4_qv_r    <= s3_qv_r;
      s4_pp_lo_r <= s3_qv_r * rk4sa_pkg::RECIP_THREE[16:0];
      s4_pp_hi_r <= s3_qv_r * rk4sa_pkg::RECIP_THREE[QW-1:17];

      s5_op_r    <= s4_op_r;
      s5_elem_r  <= s4_elem_r;
      s5_val_r   <= s4_val_r;
      s5_term_r  <= s5_term_nxt;

      out_element_out  <= s5_elem_r;
      out_result_value <= res;
      out_is_new_state <= (s5_op_r == rk4sa_pkg::OP_LOAD) ||
                          (s5_op_r == rk4sa_pkg::OP_FINAL);
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/rk4_stage_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// RK4 stage accumulator core
// Per-element fourth-order Runge-Kutta update in signed Q15.16 arithmetic.
// ----------------------------------------------------------------------------
// Streams one transaction per clock while out_stall is low. A load (kind 0) sets an element's
// state and echoes it. A derivative (kind 1) at stage 1..3 stores the slope
// and returns x + k*dt/2 (stages 1, 2) or x + k*dt (stage 3); at stage 4 it
// forms (k1 + 2k2 + 2k3 + k4)/6, returns and stores x + phi*dt, with
// is_new_state set. Terms round to nearest, ties away from zero, and the
// sum saturates to 32 bits. Items with an element at or above VECTOR_LENGTH,
// or a derivative with a stage outside 1..4, are taken and dropped silently.
// Rate: one transaction per cycle sustained while out_stall is low. A result
// leaves the output register after the command queue and the datapath
// stages (slope sum, multiply by dt, round, divide by three, saturate),
// which are all held by the output stall. The QUEUE_DEPTH-entry queue
// keeps taking input while results back up, until it is full.
// Slopes are read and written at issue and the state at the last stage, so
// back-to-back items on the same element need no bypass. Storage clears at
// reset through per-entry valid bits; there is no clearing pass.
// timestep (dt, unsigned Q0.16, reset 655) is written through cfg_wr_en /
// cfg_wr_data and may only change while no transaction is in flight.
// ----------------------------------------------------------------------------
module rk4_stage_accumulator_core #(
  parameter int VECTOR_LENGTH = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [rk4sa_pkg::DT_W-1:0]          cfg_wr_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [rk4sa_pkg::ELEM_W-1:0]        in_element,
  input  logic [rk4sa_pkg::STAGE_W-1:0]       in_stage,
  input  logic signed [rk4sa_pkg::DATA_W-1:0] in_operand,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rk4sa_pkg::ELEM_W-1:0]        out_element_out,
  output logic signed [rk4sa_pkg::DATA_W-1:0] out_result_value,
  output logic                                out_is_new_state
);

  logic [rk4sa_pkg::DT_W-1:0] timestep_r;

  logic            q_push, q_full, q_pop, q_empty;
  rk4sa_pkg::cmd_t q_push_cmd, q_pop_cmd;

  // dt register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timestep_r <= rk4sa_pkg::TIMESTEP_RST;
    end else if (cfg_wr_en) begin
      timestep_r <= cfg_wr_data;
    end
  end

  // front: accept and classify
  rk4sa_front #(
    .VECTOR_LENGTH (VECTOR_LENGTH)
  ) u_front (
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_element (in_element),
    .in_stage   (in_stage),
    .in_operand (in_operand),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_push_cmd)
  );

  // command queue between front and back
  rk4sa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .empty    (q_empty)
  );

  // back: arithmetic pipeline, element storage, output register
  rk4sa_back #(
    .VECTOR_LENGTH (VECTOR_LENGTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .timestep         (timestep_r),
    .q_empty          (q_empty),
    .q_cmd            (q_pop_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_element_out  (out_element_out),
    .out_result_value (out_result_value),
    .out_is_new_state (out_is_new_state)
  );

endmodule

// ===== rtl/rk4sa_chk.sv =====
// ----------------------------------------------------------------------------
// RK4 stage accumulator - port checker
// Concurrent checks on the core's ports, attached by bind.
// ----------------------------------------------------------------------------
`include "rk4_stage_accumulator_core_assert.svh"

module rk4sa_chk #(
  parameter int VECTOR_LENGTH = 16
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [rk4sa_pkg::ELEM_W-1:0]        out_element_out,
  input logic signed [rk4sa_pkg::DATA_W-1:0] out_result_value,
  input logic                                out_is_new_state
);

  // no transaction is taken while in reset
  `RK4SA_CHECK_ALWAYS(a_rst_stall, clk, !rst_n |-> in_stall, "input taken during reset")

  // reset empties the result channel
  `RK4SA_CHECK_ALWAYS(a_rst_out, clk, !rst_n |=> !out_valid, "result valid after reset")

  // dropped elements never produce results
  `RK4SA_CHECK(a_elem_range, clk, rst_n, out_valid |-> (32'(out_element_out) < VECTOR_LENGTH), "result for element out of range")

  // a stalled result holds
  `RK4SA_CHECK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_result_value) && $stable(out_element_out) && $stable(out_is_new_state), "stalled result changed")

endmodule

bind rk4_stage_accumulator_core rk4sa_chk #(
  .VECTOR_LENGTH (VECTOR_LENGTH)
) u_rk4sa_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_element_out  (out_element_out),
  .out_result_value (out_result_value),
  .out_is_new_state (out_is_new_state)
);
